// ===== hw/rtl/b64_pkg.sv =====
package b64_pkg;

  // Operating mode held in the configuration register.
  typedef enum logic {
    ModeEncode = 1'b0,
    ModeDecode = 1'b1
  } mode_e;

  // One input item.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [7:0] out_value;
    logic       out_last;
    logic       error;
  } result_t;

  // A finished group handed from the front end to the back end.
  typedef struct packed {
    mode_e       mode;
    logic [23:0] bits;       // bytes (encode) or sextets (decode), first one on top
    logic [1:0]  final_idx;  // index of the group's last result
    logic [1:0]  pad_cnt;    // encode only: number of trailing '=' characters
    logic        msg_last;   // group closes the message
    logic        error;      // decode length error request
  } job_t;

  localparam logic [7:0] PadChar   = 8'h3D;  // '='
  localparam logic [7:0] PlusChar  = 8'h2B;  // '+'
  localparam logic [7:0] SlashChar = 8'h2F;  // '/'

  // Standard alphabet: sextet value to character.
  function automatic logic [7:0] alphabet_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = PlusChar;
    end else begin
      c = SlashChar;
    end
    return c;
  endfunction

  // Character to sextet value; anything outside the alphabet maps to zero.
  function automatic logic [5:0] sextet_of(input logic [7:0] c);
    logic [7:0] s;
    if (c >= 8'h41 && c <= 8'h5A) begin
      s = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s = c - 8'h61 + 8'd26;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s = c - 8'h30 + 8'd52;
    end else if (c == PlusChar) begin
      s = 8'd62;
    end else if (c == SlashChar) begin
      s = 8'd63;
    end else begin
      s = 8'd0;
    end
    return s[5:0];
  endfunction

endpackage

// ===== hw/rtl/base64_stream_codec.sv =====
// Streaming base64 codec with the standard alphabet and '=' padding.
// Input queue side: item_i carries one byte and a last flag; it is taken when
// push is high and full is low. Result side: while empty is low the
// oldest result sits on result_o and is taken when pop is high.
// Configuration: cfg_data_i selects encode (0) or decode (1); it is written
// when cfg_valid_i is high (cfg_ready_o is always high) and clears any
// partial group. Write it only while the block is idle.
// Encoding: each third byte, or a last byte, yields four characters.
// Decoding: each fourth character yields one to three bytes; a last mark in
// the middle of a group yields a single error result.
// The first result of a group passes through the group queue and then the
// back end's job register before it shows. While pop is held high, results
// leave at one per cycle from the back end, so a run of groups sustains one
// input per cycle when decoding, while encoding yields four characters per
// three bytes and so takes fewer; the rate is set by the one-result-per-cycle
// output sequencer. A two-entry group queue sits between the input front end
// and that sequencer, so input keeps flowing while results wait. When pop is
// held low the results stay put, the group queue fills and full rises. Reset
// empties both queues, clears the group and selects encode.
module base64_stream_codec import b64_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    cfg_valid_i,
  output logic    cfg_ready_o,
  input  logic    cfg_data_i,
  input  logic    push,
  output logic    full,
  input  item_t   item_i,
  input  logic    pop,
  output logic    empty,
  output result_t result_o
);

  logic job_push;
  job_t job_in;
  logic job_pop;
  job_t job_out;
  logic job_empty;
  logic accept;

  // Configuration is always accepted.
  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  b64_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .item_i      (item_i),
    .job_push_o  (job_push),
    .job_o       (job_in)
  );

  b64_job_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (job_pop),
    .job_o   (job_out),
    .empty_o (job_empty)
  );

  b64_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .result_o    (result_o)
  );

endmodule

// ===== hw/rtl/b64_front.sv =====
module b64_front import b64_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  cfg_valid_i,
  input  logic  cfg_data_i,
  input  logic  accept_i,
  input  item_t item_i,
  output logic  job_push_o,
  output job_t  job_o
);

  mode_e       mode_q, mode_d;
  logic [23:0] held_q, held_d;
  logic [1:0]  gc_q, gc_d;
  logic        third_q, third_d;

  logic [1:0]  enc_gc;
  logic [23:0] enc_merged;
  logic        is_pad;
  logic [5:0]  sx;
  logic [23:0] dec_merged;
  logic        third_pad;
  logic [1:0]  drop_cnt;

  // Merge the new byte or sextet into the group being collected.
  always_comb begin
    enc_gc = (gc_q == 2'd3) ? 2'd2 : gc_q;
    case (enc_gc)
      2'd0:    enc_merged = held_q | {item_i.data_byte, 16'h0000};
      2'd1:    enc_merged = held_q | {8'h00, item_i.data_byte, 8'h00};
      default: enc_merged = held_q | {16'h0000, item_i.data_byte};
    endcase

    is_pad = (item_i.data_byte == PadChar);
    sx     = is_pad ? 6'd0 : sextet_of(item_i.data_byte);
    case (gc_q)
      2'd0:    dec_merged = held_q | {sx, 18'h00000};
      2'd1:    dec_merged = held_q | {6'h00, sx, 12'h000};
      2'd2:    dec_merged = held_q | {12'h000, sx, 6'h00};
      default: dec_merged = held_q | {18'h00000, sx};
    endcase
    third_pad = (gc_q == 2'd2) ? is_pad : third_q;
    drop_cnt  = item_i.last ? ({1'b0, is_pad} + {1'b0, third_pad}) : 2'd0;
  end

  // Group state update and job request generation.
  always_comb begin
    mode_d     = mode_q;
    held_d     = held_q;
    gc_d       = gc_q;
    third_d    = third_q;
    job_push_o = 1'b0;
    job_o      = '{mode: mode_q, bits: 24'h000000, final_idx: 2'd0, pad_cnt: 2'd0,
                   msg_last: 1'b0, error: 1'b0};

    if (cfg_valid_i) begin
      mode_d  = mode_e'(cfg_data_i);
      held_d  = '0;
      gc_d    = '0;
      third_d = 1'b0;
    end else if (accept_i) begin
      if (mode_q == ModeEncode) begin
        if (enc_gc == 2'd2 || item_i.last) begin
          // Full group, or a partial group closed with padding.
          job_push_o       = 1'b1;
          job_o.bits       = enc_merged;
          job_o.final_idx  = 2'd3;
          job_o.pad_cnt    = (enc_gc == 2'd2) ? 2'd0 : ((enc_gc == 2'd0) ? 2'd2 : 2'd1);
          job_o.msg_last   = item_i.last;
          held_d           = '0;
          gc_d             = '0;
          third_d          = 1'b0;
        end else begin
          held_d = enc_merged;
          gc_d   = enc_gc + 2'd1;
        end
      end else begin
        if (gc_q == 2'd3) begin
          // Fourth character: up to three bytes, fewer on a padded final group.
          job_push_o      = 1'b1;
          job_o.bits      = dec_merged;
          job_o.final_idx = 2'd2 - drop_cnt;
          job_o.msg_last  = item_i.last;
          held_d          = '0;
          gc_d            = '0;
          third_d         = 1'b0;
        end else if (item_i.last) begin
          // Message length not a multiple of four.
          job_push_o     = 1'b1;
          job_o.msg_last = 1'b1;
          job_o.error    = 1'b1;
          held_d         = '0;
          gc_d           = '0;
          third_d        = 1'b0;
        end else begin
          held_d  = dec_merged;
          gc_d    = gc_q + 2'd1;
          third_d = third_pad;
        end
      end
    end
  end

  // Control and group registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeEncode;
      held_q  <= '0;
      gc_q    <= '0;
      third_q <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      held_q  <= held_d;
      gc_q    <= gc_d;
      third_q <= third_d;
    end
  end

endmodule

// ===== hw/rtl/b64_job_fifo.sv =====
module b64_job_fifo import b64_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output job_t job_o,
  output logic empty_o
);

  job_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  // Occupancy and pointer tracking.
  always_comb begin
    full_o   = (cnt_q == 2'd2);
    empty_o  = (cnt_q == 2'd0);
    do_push  = push_i && !full_o;
    do_pop   = pop_i && !empty_o;
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    job_o    = mem_q[rd_ptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

// ===== hw/rtl/b64_back.sv =====
module b64_back import b64_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    job_empty_i,
  input  job_t    job_i,
  output logic    job_pop_o,
  output logic    empty_o,
  input  logic    pop_i,
  output result_t result_o
);

  job_t       job_q, job_d;
  logic       valid_q, valid_d;
  logic [1:0] k_q, k_d;
  logic       take;
  logic       at_final;
  logic [5:0] sextet;
  logic [7:0] byte_val;
  logic [2:0] enc_pos;

  // Result sequencing: one result per pop, next job loaded on the final one or when none is held.
  always_comb begin
    take      = pop_i && valid_q;
    at_final  = (k_q == job_q.final_idx);
    job_pop_o = !job_empty_i && (!valid_q || (take && at_final));
    job_d     = job_q;
    valid_d   = valid_q;
    k_d       = k_q;
    if (job_pop_o) begin
      job_d   = job_i;
      valid_d = 1'b1;
      k_d     = '0;
    end else if (take) begin
      if (at_final) begin
        valid_d = 1'b0;
      end else begin
        k_d = k_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      k_q     <= '0;
    end else begin
      valid_q <= valid_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  // Select the sextet or byte for the current result.
  always_comb begin
    case (k_q)
      2'd0:    sextet = job_q.bits[23:18];
      2'd1:    sextet = job_q.bits[17:12];
      2'd2:    sextet = job_q.bits[11:6];
      default: sextet = job_q.bits[5:0];
    endcase
    case (k_q)
      2'd0:    byte_val = job_q.bits[23:16];
      2'd1:    byte_val = job_q.bits[15:8];
      default: byte_val = job_q.bits[7:0];
    endcase
    enc_pos = {1'b0, k_q} + {1'b0, job_q.pad_cnt};
  end

  // Result formatting.
  always_comb begin
    empty_o = !valid_q;
    if (job_q.mode == ModeEncode) begin
      result_o.out_value = enc_pos[2] ? PadChar : alphabet_char(sextet);
    end else begin
      result_o.out_value = job_q.error ? 8'h00 : byte_val;
    end
    result_o.out_last = at_final && job_q.msg_last;
    result_o.error    = job_q.error;
  end

endmodule

// ===== hw/rtl/b64_checker.sv =====
module b64_checker import b64_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    pop,
  input logic    empty,
  input result_t result_i
);

  // Nothing is waiting right after reset.
  a_empty_after_reset: assert property (@(posedge clk_i)
    disable iff (!rst_ni) !$past(rst_ni) |-> empty)
    else $error("result queue not empty after reset");

  // An error result always closes its message.
  a_error_is_last: assert property (@(posedge clk_i)
    disable iff (!rst_ni) (!empty && result_i.error) |-> result_i.out_last)
    else $error("error result without last flag");

  // An error result carries a zero value.
  a_error_zero: assert property (@(posedge clk_i)
    disable iff (!rst_ni) (!empty && result_i.error) |-> (result_i.out_value == 8'h00))
    else $error("error result with nonzero value");

  // A stalled result stays on the ports unchanged.
  a_stall_holds: assert property (@(posedge clk_i)
    disable iff (!rst_ni) (!empty && !pop) |=> (!empty && $stable(result_i)))
    else $error("stalled result changed");

endmodule

bind base64_stream_codec b64_checker u_b64_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .pop      (pop),
  .empty    (empty),
  .result_i (result_o)
);

// ===== tb/base64_stream_checker.sv =====
`timescale 1ns / 1ps

// Watches the configuration, input and result channels of the codec. It keeps
// its own copy of the group state and lists the results each request owes.
module base64_stream_checker import b64_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    cfg_valid_i,
  input  logic    cfg_ready_i,
  input  logic    cfg_data_i,
  input  logic    push_i,
  input  logic    full_i,
  input  item_t   item_i,
  input  logic    pop_i,
  input  logic    empty_i,
  input  result_t result_i,
  output int      fail_cnt_o,
  output int      due_cnt_o
);

  // Standard alphabet, first character in the top byte.
  localparam logic [511:0] Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  mode_e       mode_q;
  logic [23:0] held_q;
  int unsigned fill_q;
  logic        third_pad_q;
  result_t     due_results[$];
  int          fail_cnt = 0;

  assign fail_cnt_o = fail_cnt;

  function automatic logic [7:0] sextet_char(input logic [5:0] s);
    return Alphabet[8 * (63 - s) +: 8];
  endfunction

  // Reverse lookup; anything that is not in the alphabet counts as zero.
  function automatic logic [5:0] char_sextet(input logic [7:0] c);
    logic [6:0] k;
    for (k = 0; k < 64; k++) begin
      if (sextet_char(k[5:0]) == c) begin
        return k[5:0];
      end
    end
    return 6'd0;
  endfunction

  function automatic result_t make_result(input logic [7:0] v, input logic l, input logic e);
    result_t r;
    r.out_value = v;
    r.out_last  = l;
    r.error     = e;
    return r;
  endfunction

  // Appends one owed result behind the ones already waiting.
  function automatic void owe_result(input result_t r);
    due_results = {due_results, r};
  endfunction

  function automatic void clear_group();
    held_q      = '0;
    fill_q      = 0;
    third_pad_q = 1'b0;
  endfunction

  // Adds one accepted request to the group and queues the results it owes.
  function automatic void predict_codec_output(input item_t it);
    logic [23:0] bits;
    logic        pad;
    logic [5:0]  sx;
    int          n;
    bits = held_q;
    if (mode_q == ModeEncode) begin
      bits = bits | ({16'h0, it.data_byte} << (16 - 8 * fill_q));
      if (fill_q == 2) begin
        for (int k = 0; k < 4; k++) begin
          owe_result(make_result(sextet_char(bits[18 - 6 * k +: 6]),
                                 it.last && (k == 3), 1'b0));
        end
        clear_group();
      end else if (it.last) begin
        // A short final group is completed with pad characters.
        n = fill_q + 2;
        for (int k = 0; k < 4; k++) begin
          owe_result(make_result(
            (k < n) ? sextet_char(bits[18 - 6 * k +: 6]) : PadChar, k == 3, 1'b0));
        end
        clear_group();
      end else begin
        held_q = bits;
        fill_q++;
      end
    end else begin
      pad  = (it.data_byte == PadChar);
      sx   = pad ? 6'd0 : char_sextet(it.data_byte);
      bits = bits | ({18'h0, sx} << (18 - 6 * fill_q));
      if (fill_q == 2) begin
        third_pad_q = pad;
      end
      if (fill_q == 3) begin
        // Only the message's final group drops bytes for its pads.
        n = 3;
        if (it.last && pad) begin
          n--;
        end
        if (it.last && third_pad_q) begin
          n--;
        end
        for (int k = 0; k < n; k++) begin
          owe_result(make_result(bits[16 - 8 * k +: 8],
                                 it.last && (k == n - 1), 1'b0));
        end
        clear_group();
      end else if (it.last) begin
        // Length not a multiple of four gives one error result.
        owe_result(make_result(8'h00, 1'b1, 1'b1));
        clear_group();
      end else begin
        held_q = bits;
        fill_q++;
      end
    end
  endfunction

  // Sample every channel at the rising edge, in the order the block sees them.
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      mode_q = ModeEncode;
      clear_group();
      due_results.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        mode_q = mode_e'(cfg_data_i);
        clear_group();
      end
      if (push_i && !full_i) begin
        predict_codec_output(item_i);
      end
      if (pop_i && !empty_i) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result value %h last %b error %b", $time,
                   result_i.out_value, result_i.out_last, result_i.error);
          fail_cnt++;
        end else begin
          want = due_results.pop_front();
          if (result_i.out_value !== want.out_value) begin
            $display("%0t: out_value expected %h actual %h", $time,
                     want.out_value, result_i.out_value);
            fail_cnt++;
          end
          if (result_i.out_last !== want.out_last) begin
            $display("%0t: out_last expected %b actual %b", $time,
                     want.out_last, result_i.out_last);
            fail_cnt++;
          end
          if (result_i.error !== want.error) begin
            $display("%0t: error expected %b actual %b", $time,
                     want.error, result_i.error);
            fail_cnt++;
          end
        end
      end
    end
    due_cnt_o = due_results.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import b64_pkg::*;

  localparam int SettleCycles = 10;
  localparam int StallLimit   = 2000;
  localparam int RandomItems  = 380;

  logic    clk_i;
  logic    rst_ni;
  logic    cfg_valid_i;
  logic    cfg_ready_o;
  logic    cfg_data_i;
  logic    push;
  logic    full;
  item_t   item_i;
  logic    pop = 1'b0;
  logic    empty;
  result_t result_o;

  int      fail_cnt;
  int      due_cnt;
  int      burst_left = 0;
  int      items_sent = 0;
  int      stall_cnt = 0;
  int unsigned rx_cyc = 0;
  int unsigned rx_style = 0;
  string   b64_chars =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  base64_stream_codec dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .push       (push),
    .full       (full),
    .item_i     (item_i),
    .pop        (pop),
    .empty      (empty),
    .result_o   (result_o)
  );

  base64_stream_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_i(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .push_i     (push),
    .full_i     (full),
    .item_i     (item_i),
    .pop_i      (pop),
    .empty_i    (empty),
    .result_i   (result_o),
    .fail_cnt_o (fail_cnt),
    .due_cnt_o  (due_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // The result side switches between steady draining, random stalls, a fixed
  // stutter and a slow reader that lets the internal queues fill up.
  always @(negedge clk_i) begin
    if (rx_cyc % 50 == 0) begin
      rx_style = $urandom_range(0, 3);
    end
    rx_cyc++;
    case (rx_style)
      0: begin
        pop <= 1'b1;
      end
      1: begin
        pop <= ($urandom_range(0, 3) != 0);
      end
      2: begin
        pop <= ((rx_cyc % 9) < 3);
      end
      default: begin
        pop <= ($urandom_range(0, 7) == 0);
      end
    endcase
  end

  // End the run if no request moves on any channel for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
        stall_cnt = 0;
      end else begin
        stall_cnt++;
      end
      if (stall_cnt >= StallLimit) begin
        $display("base64_stream_codec test failed");
        $finish;
      end
    end
  end

  // Sends one request; the sender works in bursts with idle gaps between them.
  task automatic send_item(input logic [7:0] b, input logic l);
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    item_i.data_byte <= b;
    item_i.last      <= l;
    push             <= 1'b1;
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_text(input string s, input bit close);
    for (int i = 0; i < s.len(); i++) begin
      send_item(s[i], close && (i == s.len() - 1));
    end
  endtask

  // Waits for every owed result, then lets work that owes none settle.
  task automatic wait_idle();
    while (due_cnt != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic set_mode(input mode_e m);
    push <= 1'b0;
    wait_idle();
    cfg_data_i  <= m;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Random bytes, mostly whole messages; some requests carry random last flags.
  task automatic send_raw_message();
    int  len;
    bit  noisy;
    len   = $urandom_range(1, 10);
    noisy = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < len; i++) begin
      send_item(8'($urandom_range(0, 255)),
                noisy ? 1'($urandom_range(0, 1)) : (i == len - 1));
    end
  endtask

  // Mostly well-formed text with random padding; the rest is loose characters.
  task automatic send_coded_message();
    int         len;
    int         groups;
    int         pads;
    logic [7:0] c;
    if ($urandom_range(0, 4) == 0) begin
      len = $urandom_range(1, 9);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 3))
          0: c = PadChar;
          1: c = 8'($urandom_range(0, 255));
          default: c = b64_chars[$urandom_range(0, 63)];
        endcase
        send_item(c, i == len - 1);
      end
    end else begin
      groups = $urandom_range(1, 3);
      pads   = $urandom_range(0, 2);
      for (int g = 0; g < groups; g++) begin
        for (int k = 0; k < 4; k++) begin
          c = b64_chars[$urandom_range(0, 63)];
          if ((g == groups - 1) && (k >= 4 - pads)) begin
            c = PadChar;
          end
          send_item(c, (g == groups - 1) && (k == 3));
        end
      end
    end
  endtask

  initial begin
    mode_e m;
    int    phase_end;
    int    phase;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = 1'b0;
    push        = 1'b0;
    item_i      = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Encoding: a full group, both short final groups, extreme byte values.
    set_mode(ModeEncode);
    send_text("Man", 1'b1);
    send_item(8'hFF, 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);
    // This byte is left in a partial group that the mode write throws away.
    send_item(8'hAB, 1'b0);

    // Decoding: pad in first place, characters outside the alphabet, pads in
    // a group that is not final, one and two final pads, a length error.
    set_mode(ModeDecode);
    send_item(PadChar, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h2E, 1'b0);
    send_text("AB==", 1'b0);
    send_text("/w==", 1'b1);
    send_text("AP8=", 1'b1);
    send_text("AB", 1'b1);

    // Random phases, each under a fresh mode write.
    phase = 0;
    phase_end = items_sent + RandomItems;
    while (items_sent < phase_end) begin
      if (phase < 2) begin
        m = mode_e'(phase[0]);
      end else begin
        m = mode_e'($urandom_range(0, 1));
      end
      set_mode(m);
      for (int stop = items_sent + $urandom_range(35, 60);
           items_sent < stop && items_sent < phase_end; ) begin
        if (m == ModeEncode) begin
          send_raw_message();
        end else begin
          send_coded_message();
        end
      end
      phase++;
    end

    push <= 1'b0;
    wait_idle();
    if (fail_cnt == 0) begin
      $display("base64_stream_codec test passed");
    end else begin
      $display("base64_stream_codec test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/b64_pkg.sv
hw/rtl/b64_front.sv
hw/rtl/b64_job_fifo.sv
hw/rtl/b64_back.sv
hw/rtl/base64_stream_codec.sv
hw/rtl/b64_checker.sv
tb/base64_stream_checker.sv
tb/tb.sv
